@@ src/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int VALUE_W        = 32;
   localparam int WSIZE_W        = 7;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 2;
   localparam int MAX_WINDOW_DEF = 64;

   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_SIZE = 2'd0;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic step;    // update the chain this cycle
      logic shift;   // take the entry of the next cell (front leaves)
      logic clear;   // forget every kept entry
      logic cmp;     // drop entries smaller than the new word
      logic append;  // place the new word behind the last kept entry
   } cell_ctrl_type;

endpackage

@@ src/swm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the candidate queue: keeps a value and its position, decides
// whether it survives the new word and hands its entry to its front neighbor.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int POS_W = 7,
   parameter bit HEAD  = 1'b0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swm_pkg::cell_ctrl_type              ctrl,
   input  logic signed [swm_pkg::VALUE_W-1:0]  x_value,
   input  logic        [POS_W-1:0]             x_pos,
   input  logic                                prev_keep,
   input  logic                                next_keep,
   input  logic signed [swm_pkg::VALUE_W-1:0]  next_value,
   input  logic        [POS_W-1:0]             next_pos,
   output logic                                keep,
   output logic                                valid,
   output logic signed [swm_pkg::VALUE_W-1:0]  value,
   output logic        [POS_W-1:0]             pos
);

   logic                               valid_ff, valid_in;
   logic signed [swm_pkg::VALUE_W-1:0] value_ff, value_in;
   logic        [POS_W-1:0]            pos_ff, pos_in;
   logic                               src_keep, src_prev;

   assign keep = valid_ff && !ctrl.clear && !(ctrl.cmp && (value_ff < x_value));

   always_comb begin
      src_keep = ctrl.shift ? next_keep : keep;
      src_prev = ctrl.shift ? (keep || HEAD) : prev_keep;
      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctrl.step) begin
         if (src_keep) begin
            valid_in = 1'b1;
            value_in = ctrl.shift ? next_value : value_ff;
            pos_in   = ctrl.shift ? next_pos : pos_ff;
         end else if (ctrl.append && src_prev) begin
            valid_in = 1'b1;
            value_in = x_value;
            pos_in   = x_pos;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign pos   = pos_ff;

endmodule

@@ src/sliding_window_maximum_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_top
// Running maximum over the last window_size signed words of a sequence.
//
// req_ carries one sample per word (tdata) with a start flag (tuser) that
// opens a new sequence. rsp_ returns the window maximum once window_size
// words of the sequence have arrived; earlier words give no result.
// One word per cycle is taken; the result sits in the output register the
// cycle after acceptance. A rsp_ stall holds that register and blocks req_
// until the result is taken or taken in the same cycle.
// Candidates live in a chain of MAX_WINDOW cells, front at cell 0; each
// word compares against all cells at once; the chain shifts by one
// when the front candidate has aged. After window_size is lowered,
// req_tready stays low while the chain drops aged candidates from the front.
// Reset empties the chain, sets window_size to 1 and starts a fresh
// sequence. The window register is written at csr_ address 0.
// ----------------------------------------------------------------------------
module sliding_window_maximum_top #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample
   input  logic [swm_pkg::VALUE_W-1:0]       req_tdata,
   // start_req
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // window_max
   output logic [swm_pkg::VALUE_W-1:0]       rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int POS_MOD = 2 * MAX_WINDOW;
   localparam int POS_W   = $clog2(POS_MOD);
   localparam int WIN_W   = ($clog2(MAX_WINDOW + 1) > swm_pkg::WSIZE_W) ?
                            $clog2(MAX_WINDOW + 1) : swm_pkg::WSIZE_W;
   localparam int CMP_W   = ((POS_W + 1) > WIN_W) ? (POS_W + 1) : WIN_W;

   logic [swm_pkg::WSIZE_W-1:0]      window_size_ff, window_size_in;
   logic [POS_W-1:0]                 sample_pos_ff, sample_pos_in;
   logic                             filled_ff, filled_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [swm_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WIN_W-1:0]                 ws_ext;
   logic [CMP_W-1:0]                 win;
   logic                             csr_write;
   logic                             req_accept;
   logic                             purge;
   logic                             aged0, aged1;
   logic                             start;
   logic [POS_W-1:0]                 pos;
   logic signed [swm_pkg::VALUE_W-1:0] x;
   logic signed [swm_pkg::VALUE_W-1:0] front;
   swm_pkg::cell_ctrl_type           ctrl;

   logic                               c_keep  [MAX_WINDOW];
   logic                               c_valid [MAX_WINDOW];
   logic signed [swm_pkg::VALUE_W-1:0] c_value [MAX_WINDOW];
   logic        [POS_W-1:0]            c_pos   [MAX_WINDOW];

   function automatic logic [CMP_W-1:0] age_of(input logic [POS_W-1:0] now,
                                               input logic [POS_W-1:0] then);
      logic [POS_W:0] diff;
      diff = {1'b0, now} - {1'b0, then};
      if (now < then) begin
         diff = diff + (POS_W + 1)'(POS_MOD);
      end
      return CMP_W'(diff);
   endfunction

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == swm_pkg::ADDR_WINDOW_SIZE) ?
                       swm_pkg::CSR_DATA_W'(window_size_ff) : '0;

   always_comb begin
      window_size_in = window_size_ff;
      if (csr_write && (csr_paddr == swm_pkg::ADDR_WINDOW_SIZE)) begin
         window_size_in = csr_pwdata[swm_pkg::WSIZE_W-1:0];
      end
   end

   // effective window, clamped to 1..MAX_WINDOW
   always_comb begin
      ws_ext = WIN_W'(window_size_ff);
      if (ws_ext == '0) begin
         win = CMP_W'(1);
      end else if (ws_ext > WIN_W'(MAX_WINDOW)) begin
         win = CMP_W'(MAX_WINDOW);
      end else begin
         win = CMP_W'(ws_ext);
      end
   end

   // aging of the two front cells against the next position
   assign aged0 = c_valid[0] && (age_of(sample_pos_ff, c_pos[0]) >= win);
   assign aged1 = c_valid[1] && (age_of(sample_pos_ff, c_pos[1]) >= win);
   assign purge = aged1;

   assign req_tready = !purge && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign start      = req_tuser;
   assign x          = req_tdata;
   assign pos        = start ? '0 : sample_pos_ff;

   always_comb begin
      ctrl = '0;
      if (purge) begin
         ctrl.step  = 1'b1;
         ctrl.shift = 1'b1;
      end else if (req_accept) begin
         ctrl.step   = 1'b1;
         ctrl.shift  = !start && aged0;
         ctrl.clear  = start;
         ctrl.cmp    = 1'b1;
         ctrl.append = 1'b1;
      end
   end

   // front of the queue once this word is in
   always_comb begin
      if (ctrl.shift) begin
         front = c_keep[1] ? c_value[1] : x;
      end else begin
         front = c_keep[0] ? c_value[0] : x;
      end
   end

   always_comb begin
      sample_pos_in = sample_pos_ff;
      filled_in     = filled_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         sample_pos_in = (pos == POS_W'(POS_MOD - 1)) ? '0 : pos + POS_W'(1);
         filled_in     = (!start && filled_ff) ||
                         ((CMP_W'(pos) + CMP_W'(1)) >= win);
         rsp_valid_in  = filled_in;
         rsp_data_in   = front;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WSIZE_W'(1);
         sample_pos_ff  <= '0;
         filled_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         sample_pos_ff  <= sample_pos_in;
         filled_ff      <= filled_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // candidate chain
   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      logic                               prev_keep;
      logic                               next_keep;
      logic signed [swm_pkg::VALUE_W-1:0] next_value;
      logic        [POS_W-1:0]            next_pos;

      if (j == 0) begin : g_head
         assign prev_keep = 1'b1;
      end else begin : g_body
         assign prev_keep = c_keep[j-1];
      end

      if (j == MAX_WINDOW - 1) begin : g_tail
         assign next_keep  = 1'b0;
         assign next_value = '0;
         assign next_pos   = '0;
      end else begin : g_link
         assign next_keep  = c_keep[j+1];
         assign next_value = c_value[j+1];
         assign next_pos   = c_pos[j+1];
      end

      swm_cell #(
         .POS_W (POS_W),
         .HEAD  (j == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .x_value    (x),
         .x_pos      (pos),
         .prev_keep  (prev_keep),
         .next_keep  (next_keep),
         .next_value (next_value),
         .next_pos   (next_pos),
         .keep       (c_keep[j]),
         .valid      (c_valid[j]),
         .value      (c_value[j]),
         .pos        (c_pos[j])
      );
   end

   a_front_contiguous : assert property (@(posedge clock) disable iff (reset)
      c_valid[1] |-> c_valid[0])
      else $error("queue has a gap at the front");

   a_start_single : assert property (@(posedge clock) disable iff (reset)
      (req_accept && start) |=> (c_valid[0] && !c_valid[1]))
      else $error("start did not leave a single candidate");

   a_purge_blocks : assert property (@(posedge clock) disable iff (reset)
      purge |-> !req_tready)
      else $error("word accepted while aged candidates remain");

   a_result_after_fill : assert property (@(posedge clock) disable iff (reset)
      (req_accept && start && (win == CMP_W'(1))) |=> rsp_tvalid)
      else $error("window of one gave no result");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the sliding window maximum block.
//
// Samples enter on req_, window maxima leave on rsp_, and the window length
// is set through the csr_ port. A behavioral deque tracks the kept
// candidates of each accepted word and queues the maximum that the block
// must return; each returned word is checked against the oldest queued
// value. Directed tests cover reset defaults, register access, sample
// extremes, a zero window, window changes inside a sequence and one long
// output stall. Random traffic then runs sequences of several shapes over
// many window settings, with bursty input and an irregular output stall.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_WIN        = swm_pkg::MAX_WINDOW_DEF;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 800;
   localparam int EXP_DEPTH      = 16;
   localparam int STALL_ITEMS    = 30;

   localparam logic [swm_pkg::CSR_ADDR_W-1:0] ADDR_UNUSED = 2'd2;

   localparam logic signed [swm_pkg::VALUE_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [swm_pkg::VALUE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

   // sequence shapes
   localparam int SEQ_RANDOM   = 0;
   localparam int SEQ_NARROW   = 1;
   localparam int SEQ_FALLING  = 2;
   localparam int SEQ_RISING   = 3;
   localparam int SEQ_EXTREMES = 4;

   // receiver stall patterns
   localparam int RX_ALWAYS   = 0;
   localparam int RX_RANDOM   = 1;
   localparam int RX_PERIODIC = 2;
   localparam int RX_SPARSE   = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [swm_pkg::VALUE_W-1:0]    req_tdata   = '0;
   logic                           req_tuser   = 1'b0;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [swm_pkg::VALUE_W-1:0]    rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [swm_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [swm_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [swm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // deque tracking state
   logic signed [swm_pkg::VALUE_W-1:0] cand_val [MAX_WIN];
   logic [swm_pkg::WSIZE_W-1:0]        cand_pos [MAX_WIN];
   logic [5:0]                         q_head      = '0;
   logic [swm_pkg::WSIZE_W-1:0]        q_count     = '0;
   logic [swm_pkg::WSIZE_W-1:0]        next_pos    = '0;
   logic                               window_full = 1'b0;
   logic [swm_pkg::WSIZE_W-1:0]        window_reg  = 7'd1;

   // expected results, oldest at exp_rd
   logic signed [swm_pkg::VALUE_W-1:0] expected_max [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;
   logic signed [swm_pkg::VALUE_W-1:0] want;
   int mismatch_count = 0;

   // sender and receiver control
   int burst_left   = 0;
   bit sender_idles = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int rx_mode      = RX_ALWAYS;
   int rx_mode_left = 0;
   int rx_tick      = 0;
   int idle_cycles  = 0;

   sliding_window_maximum_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),   // [31:0] sample
      .req_tuser   (req_tuser),   // [0] start_req
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),   // [31:0] window_max
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int clamp_window(input logic [swm_pkg::WSIZE_W-1:0] value);
      int w;
      w = value;
      if (w < 1) w = 1;
      if (w > MAX_WIN) w = MAX_WIN;
      return w;
   endfunction

   function automatic logic [5:0] slot_at(input int offset);
      logic [5:0] slot;
      slot = q_head + offset[5:0];
      return slot;
   endfunction

   // advance the candidate deque by one accepted word
   task automatic predict_window_max(input logic signed [swm_pkg::VALUE_W-1:0] sample,
                                     input logic start);
      int w;
      logic [swm_pkg::WSIZE_W-1:0] pos;
      logic [swm_pkg::WSIZE_W-1:0] age;
      bit aged;
      w = clamp_window(window_reg);
      if (start) begin
         q_head      = '0;
         q_count     = '0;
         next_pos    = '0;
         window_full = 1'b0;
      end
      pos  = next_pos;
      aged = 1'b1;
      while (q_count != 0 && aged) begin
         age = pos - cand_pos[q_head];
         if (age >= w) begin
            q_head  = q_head + 1'b1;
            q_count = q_count - 1'b1;
         end else begin
            aged = 1'b0;
         end
      end
      while (q_count != 0 && cand_val[slot_at(int'(q_count) - 1)] < sample)
         q_count = q_count - 1'b1;
      if (q_count >= MAX_WIN) begin
         q_head  = q_head + 1'b1;
         q_count = q_count - 1'b1;
      end
      cand_val[slot_at(int'(q_count))] = sample;
      cand_pos[slot_at(int'(q_count))] = pos;
      q_count = q_count + 1'b1;
      if (int'(pos) + 1 >= w) window_full = 1'b1;
      next_pos = pos + 1'b1;
      if (window_full) begin
         expected_max[exp_wr % EXP_DEPTH] = cand_val[q_head];
         exp_wr++;
      end
   endtask

   // check returned words, then track accepted ones
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (exp_wr == exp_rd) begin
               $error("window_max: no word expected, actual %0d", $signed(rsp_tdata));
               mismatch_count++;
            end else begin
               want = expected_max[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_tdata !== want) begin
                  $error("window_max: expected %0d, actual %0d", want, $signed(rsp_tdata));
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_window_max($signed(req_tdata), req_tuser);
      end
   end

   // output stall pattern, with an occasional long hold
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_ALWAYS, RX_SPARSE);
            rx_mode_left = $urandom_range(10, 120);
         end
         rx_mode_left--;
         rx_tick++;
         case (rx_mode)
            RX_ALWAYS:   rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= ($urandom_range(0, 99) < 60);
            RX_PERIODIC: rsp_tready <= (rx_tick % 3 != 0);
            default:     rsp_tready <= (rx_tick % 7 < 2);
         endcase
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_sample(input logic signed [swm_pkg::VALUE_W-1:0] sample,
                              input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (sender_idles && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [swm_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [swm_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == swm_pkg::ADDR_WINDOW_SIZE) window_reg = data[swm_pkg::WSIZE_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input logic [swm_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [swm_pkg::CSR_DATA_W-1:0] want_rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want_rd) begin
         $error("window_size: expected %0d, actual %0d", want_rd, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [swm_pkg::CSR_DATA_W-1:0] value);
      wait_results_drained();
      csr_write(swm_pkg::ADDR_WINDOW_SIZE, value);
      csr_check(swm_pkg::ADDR_WINDOW_SIZE, {25'd0, value[swm_pkg::WSIZE_W-1:0]});
   endtask

   function automatic logic signed [swm_pkg::VALUE_W-1:0] next_value(
      input int shape, input logic signed [swm_pkg::VALUE_W-1:0] prev);
      logic signed [swm_pkg::VALUE_W-1:0] v;
      case (shape)
         SEQ_NARROW:  v = $urandom_range(0, 6) - 3;
         SEQ_FALLING: v = prev - $urandom_range(0, 3);
         SEQ_RISING:  v = prev + $urandom_range(0, 3);
         SEQ_EXTREMES: begin
            case ($urandom_range(0, 4))
               0:       v = S32_MIN;
               1:       v = S32_MAX;
               2:       v = '0;
               3:       v = -1;
               default: v = $urandom;
            endcase
         end
         default:     v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_sequence(input int w, input bit with_start, inout int sent);
      int len;
      int shape;
      logic signed [swm_pkg::VALUE_W-1:0] v;
      logic start;
      if ($urandom_range(0, 4) == 0)
         len = $urandom_range(1, w);
      else
         len = w + $urandom_range(0, w + 12);
      shape = $urandom_range(SEQ_RANDOM, SEQ_EXTREMES);
      v = $urandom;
      for (int i = 0; i < len; i++) begin
         v = next_value(shape, v);
         start = (i == 0) ? with_start : ($urandom_range(0, 63) == 0);
         send_sample(v, start);
      end
      sent += len;
   endtask

   task automatic test_reset_state();
      csr_check(swm_pkg::ADDR_WINDOW_SIZE, 32'd1);
      send_sample(32'sd5, 1'b0);
      send_sample(-32'sd7, 1'b0);
      send_sample(S32_MAX, 1'b0);
   endtask

   task automatic test_register_access();
      set_window(32'd127);
      set_window(32'd0);
      set_window(32'hFFFF_FFC0);
      wait_results_drained();
      csr_write(ADDR_UNUSED, 32'd9);
      csr_check(swm_pkg::ADDR_WINDOW_SIZE, 32'd64);
   endtask

   task automatic test_sample_extremes();
      set_window(32'd3);
      send_sample(S32_MIN, 1'b1);
      send_sample(S32_MIN, 1'b0);
      send_sample(S32_MAX, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(S32_MIN, 1'b0);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd5, 1'b0);
   endtask

   task automatic test_window_zero();
      set_window(32'd0);
      send_sample(32'sd11, 1'b1);
      send_sample(-32'sd11, 1'b0);
   endtask

   task automatic test_window_change();
      set_window(32'd6);
      for (int i = 0; i < 8; i++)
         send_sample(32'sd100 - i, i == 0);
      set_window(32'd2);
      for (int i = 0; i < 3; i++)
         send_sample(32'sd50 - i, 1'b0);
      set_window(32'd9);
      send_sample(32'sd60, 1'b0);
      send_sample(32'sd40, 1'b0);
   endtask

   task automatic test_output_stall();
      set_window(32'd2);
      sender_idles = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < STALL_ITEMS; i++)
         send_sample($urandom, i == 0);
      sender_idles = 1'b1;
      wait_results_drained();
   endtask

   task automatic test_random_traffic();
      int window_plan [0:11] = '{1, 2, 3, 5, 8, 16, 31, 63, 64, 65, 127, 0};
      int phase;
      int sent;
      int phase_end;
      int w;
      logic [swm_pkg::CSR_DATA_W-1:0] setting;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 12)
            setting = window_plan[phase];
         else if ($urandom_range(0, 1) == 0)
            setting = $urandom_range(1, 12);
         else
            setting = $urandom;
         set_window(setting);
         w = clamp_window(setting[swm_pkg::WSIZE_W-1:0]);
         sender_idles = ($urandom_range(0, 3) != 0);
         phase_end = sent + ((w + 20 > 50) ? w + 20 : 50);
         send_sequence(w, $urandom_range(0, 3) != 0, sent);
         while (sent < phase_end)
            send_sequence(w, 1'b1, sent);
         phase++;
      end
      sender_idles = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_register_access();
      test_sample_extremes();
      test_window_zero();
      test_window_change();
      test_output_stall();
      test_random_traffic();
      wait_results_drained();
      if (mismatch_count == 0 && exp_wr == exp_rd)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
